// ----- src/grmd_pkg.sv -----
// Shared types and constants for the grid ray march block.
// Holds the item record that passes from the front end to the march engine.
// No dependencies.
package grmd_pkg;

  // Fixed field widths of the stream beats.
  localparam int CELL_IDX_W  = 4;
  localparam int XY_W        = 10;
  localparam int DIR_W       = 16;
  localparam int STEP_W      = 6;
  localparam int DIST_W      = 18;
  localparam int DIR_FRAC    = 14;
  localparam int INC_W       = 22;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  // Bit offsets of the input fields inside s_tdata.
  localparam int OFF_COL  = 0;
  localparam int OFF_ROW  = 4;
  localparam int OFF_WALL = 8;
  localparam int OFF_SX   = 9;
  localparam int OFF_SY   = 19;
  localparam int OFF_DX   = 29;
  localparam int OFF_DY   = 45;
  localparam int OFF_STEP = 61;

  // Bit offsets of the result fields inside m_tdata.
  localparam int OFF_DIST    = 0;
  localparam int OFF_LX      = 18;
  localparam int OFF_LY      = 28;
  localparam int OFF_BLOCKED = 38;
  localparam int OFF_LIMIT   = 39;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_RAY   = 1'b1
  } item_kind_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    item_kind_t              kind;
    logic                    wr_ok;
    logic [CELL_IDX_W-1:0]   cell_col;
    logic [CELL_IDX_W-1:0]   cell_row;
    logic                    cell_is_wall;
    logic [XY_W-1:0]         start_x;
    logic [XY_W-1:0]         start_y;
    logic signed [INC_W-1:0] inc_x;
    logic signed [INC_W-1:0] inc_y;
    logic [STEP_W-1:0]       step_size;
  } grmd_item_t;

endpackage

// ----- src/grmd_front.sv -----
// Front end of the grid ray march block: unpacks input beats, classifies them
// and keeps them in a two-entry queue for the march engine.
// Depends on grmd_pkg.
module grmd_front import grmd_pkg::*; #(
  parameter int MAP_COLS = 16,
  parameter int MAP_ROWS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0 up: cell_col, cell_row, cell_is_wall, start_x, start_y,
  // dir_x, dir_y, step_size, zero padding.
  input  logic [IN_TDATA_W-1:0] s_tdata,
  // Field: kind.
  input  logic                  s_tuser,
  input  logic                  clearing,
  input  logic                  pop,
  output logic                  head_valid,
  output grmd_item_t            head
);

  localparam int QDEPTH = 2;

  grmd_item_t              item;
  logic [STEP_W-1:0]       step;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic                    push;

  grmd_item_t              queue [QDEPTH];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              fill;

  // Unpack the beat and work out what the back end needs.
  always_comb begin
    step  = s_tdata[OFF_STEP +: STEP_W];
    dir_x = $signed(s_tdata[OFF_DX +: DIR_W]);
    dir_y = $signed(s_tdata[OFF_DY +: DIR_W]);

    item.kind         = item_kind_t'(s_tuser);
    item.cell_col     = s_tdata[OFF_COL +: CELL_IDX_W];
    item.cell_row     = s_tdata[OFF_ROW +: CELL_IDX_W];
    item.cell_is_wall = s_tdata[OFF_WALL];
    item.start_x      = s_tdata[OFF_SX +: XY_W];
    item.start_y      = s_tdata[OFF_SY +: XY_W];
    item.step_size    = step;
    // A write outside the map is dropped.
    item.wr_ok = (item.kind == KIND_WRITE) &&
                 (int'(item.cell_col) < MAP_COLS) &&
                 (int'(item.cell_row) < MAP_ROWS);
    // Per-step displacement in Q.14, step_size times the direction.
    item.inc_x = INC_W'($signed({1'b0, step})) * INC_W'(dir_x);
    item.inc_y = INC_W'($signed({1'b0, step})) * INC_W'(dir_y);
  end

  // No beat is taken while the map clear runs after reset.
  assign s_tready   = (fill != 2'(QDEPTH)) && !clearing;
  assign push       = s_tvalid && s_tready;
  assign head_valid = (fill != 2'd0);
  assign head       = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && head_valid) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop && head_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/grmd_march.sv -----
// March engine of the grid ray march block: owns the wall map, clears it after
// reset, applies cell writes and steps rays point by point, then holds the result.
// Depends on grmd_pkg.
module grmd_march import grmd_pkg::*; #(
  parameter int MAP_COLS  = 16,
  parameter int MAP_ROWS  = 16,
  parameter int CELL_SIZE = 64,
  parameter int MAX_STEPS = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  grmd_item_t             head,
  output logic                   pop,
  output logic                   clearing,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int DEPTH = MAP_ROWS * MAP_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAP_COLS);
  localparam int RW    = $clog2(MAP_ROWS);
  localparam int QIW   = (CW > RW) ? CW : RW;
  localparam int WX    = $clog2(MAP_COLS * CELL_SIZE);
  localparam int WY    = $clog2(MAP_ROWS * CELL_SIZE);
  localparam int WW    = (WX > WY) ? WX : WY;
  localparam int MW    = (WW > XY_W) ? WW : XY_W;
  localparam int ACC_W = MW + DIR_FRAC + 2;
  localparam int QW    = ACC_W - DIR_FRAC;
  localparam int LC    = $clog2(CELL_SIZE);
  localparam int SH    = WW + LC;
  // Rounded-up reciprocal of the cell size; exact for all coordinates in the map.
  localparam int RECIP = (2**SH + CELL_SIZE - 1) / CELL_SIZE;
  localparam int PW    = SH + QIW + 1;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_ADDR  = 7'b0010000,
    S_TEST  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // Wall map.
  logic            wall_map [DEPTH];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic            rdata;
  logic [AW-1:0]   clr_addr;

  // Ray state.
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [INC_W-1:0] inc_x;
  logic signed [INC_W-1:0] inc_y;
  logic [STEP_W-1:0]       step;
  logic [WW-1:0]           tx;
  logic [WW-1:0]           ty;
  logic [WW-1:0]           tx_next;
  logic [WW-1:0]           ty_next;
  logic                    pt_in;
  logic [PW-1:0]           prod_x;
  logic [PW-1:0]           prod_y;
  logic [CNT_W-1:0]        count;
  logic [DIST_W-1:0]       dist_acc;
  logic [DIST_W:0]         dist_sum;
  logic [XY_W-1:0]         lx;
  logic [XY_W-1:0]         ly;
  logic                    limit;
  logic                    load_out;

  // Result register.
  logic [DIST_W-1:0]       out_dist;
  logic [XY_W-1:0]         out_x;
  logic [XY_W-1:0]         out_y;
  logic                    out_blocked;
  logic                    out_limit;

  // Truncate each coordinate toward zero and test it against the map bounds.
  // A negative sum above minus one is still coordinate zero.
  always_comb begin
    logic in_x;
    logic in_y;
    if (acc_x[ACC_W-1]) begin
      in_x    = (&acc_x[ACC_W-1:DIR_FRAC]) && (|acc_x[DIR_FRAC-1:0]);
      tx_next = '0;
    end else begin
      in_x    = acc_x[ACC_W-1:DIR_FRAC] < QW'(MAP_COLS * CELL_SIZE);
      tx_next = acc_x[DIR_FRAC +: WW];
    end
    if (acc_y[ACC_W-1]) begin
      in_y    = (&acc_y[ACC_W-1:DIR_FRAC]) && (|acc_y[DIR_FRAC-1:0]);
      ty_next = '0;
    end else begin
      in_y    = acc_y[ACC_W-1:DIR_FRAC] < QW'(MAP_ROWS * CELL_SIZE);
      ty_next = acc_y[DIR_FRAC +: WW];
    end
    pt_in = in_x && in_y;
  end

  // Map address of the current point from the cell quotients.
  assign mem_raddr = AW'(prod_y[SH +: RW]) * AW'(MAP_COLS) + AW'(prod_x[SH +: CW]);

  // Saturating distance after one more open point.
  always_comb begin
    dist_sum = {1'b0, dist_acc} + (DIST_W + 1)'(step);
    if (dist_sum[DIST_W]) begin
      dist_sum = {1'b0, {DIST_W{1'b1}}};
    end
  end

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && head_valid;
  assign load_out = (state == S_DONE) && (!m_tvalid || m_tready);

  // Map write port: clear sweep or a cell write item.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (pop && (head.kind == KIND_WRITE)) begin
      mem_we    = head.wr_ok;
      mem_waddr = AW'(head.cell_row) * AW'(MAP_COLS) + AW'(head.cell_col);
      mem_wdata = head.cell_is_wall;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wall_map[mem_waddr] <= mem_wdata;
    end
    rdata <= wall_map[mem_raddr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop && (head.kind == KIND_RAY)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = pt_in ? S_MUL : S_DONE;
      S_MUL:   state_next = S_ADDR;
      S_ADDR:  state_next = S_TEST;
      S_TEST: begin
        if (rdata || (count == CNT_W'(MAX_STEPS - 1))) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // March datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        acc_x    <= ACC_W'({head.start_x, {DIR_FRAC{1'b0}}});
        acc_y    <= ACC_W'({head.start_y, {DIR_FRAC{1'b0}}});
        inc_x    <= head.inc_x;
        inc_y    <= head.inc_y;
        step     <= head.step_size;
        lx       <= head.start_x;
        ly       <= head.start_y;
        count    <= '0;
        dist_acc <= '0;
        limit    <= 1'b0;
      end
      S_CHECK: begin
        tx <= tx_next;
        ty <= ty_next;
      end
      S_MUL: begin
        prod_x <= PW'(tx) * PW'(RECIP);
        prod_y <= PW'(ty) * PW'(RECIP);
      end
      S_TEST: begin
        // An open point is taken and the march moves on by one step.
        if (!rdata) begin
          lx       <= XY_W'(32'(tx));
          ly       <= XY_W'(32'(ty));
          count    <= count + CNT_W'(1);
          dist_acc <= dist_sum[DIST_W-1:0];
          acc_x    <= acc_x + ACC_W'(inc_x);
          acc_y    <= acc_y + ACC_W'(inc_y);
          limit    <= (count == CNT_W'(MAX_STEPS - 1));
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dist    <= dist_acc;
      out_x       <= lx;
      out_y       <= ly;
      out_blocked <= (count == '0);
      out_limit   <= limit;
    end
  end

  assign m_tdata = {out_limit, out_blocked, out_y, out_x, out_dist};

endmodule

// ----- src/grid_ray_march_distance.sv -----
// Grid ray marcher: keeps a wall map and returns how far a ray gets before it
// hits a wall or leaves the map. Depends on grmd_pkg, grmd_front and grmd_march.
//
// A beat with kind 0 writes one map cell and gives no result; a beat with kind 1
// casts a ray and gives exactly one result beat. Items are carried out strictly
// in order. After reset the map of MAP_ROWS*MAP_COLS cells (256 by default) is
// cleared one cell per cycle, during which s_tready stays low. A cell write is
// applied as the item leaves the queue. A ray is loaded and then marched point by
// point: each point passes a bounds test, a cell-index multiply, a map read and a
// decision, in that order; a point outside the map ends the march at the bounds
// test and a wall ends it at the decision, and the result register is loaded
// last. One ray is marched at a time. A two-entry queue in front lets new beats
// arrive while a ray is marching, and the result register lets the next item
// start while a result waits.
module grid_ray_march_distance import grmd_pkg::*; #(
  parameter int MAP_COLS  = 16,
  parameter int MAP_ROWS  = 16,
  parameter int CELL_SIZE = 64,
  parameter int MAX_STEPS = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // From bit 0 up: cell_col[3:0], cell_row[7:4], cell_is_wall[8], start_x[18:9],
  // start_y[28:19], dir_x[44:29], dir_y[60:45], step_size[66:61], zeros[71:67].
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // kind: 0 writes a map cell, 1 casts a ray.
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // From bit 0 up: distance[17:0], last_x[27:18], last_y[37:28],
  // blocked_at_start[38], limit_reached[39].
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  grmd_item_t head;
  logic       head_valid;
  logic       pop;
  logic       clearing;

  // Beat intake and queue.
  grmd_front #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .clearing   (clearing),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Map store and ray march.
  grmd_march #(
    .MAP_COLS  (MAP_COLS),
    .MAP_ROWS  (MAP_ROWS),
    .CELL_SIZE (CELL_SIZE),
    .MAX_STEPS (MAX_STEPS)
  ) u_march (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for grid_ray_march_distance: directed table, then random
// map writes and rays.
// Depends on grmd_pkg and the grid_ray_march_distance RTL; expected rays come from a local march.

module tb;
  import grmd_pkg::*;

  localparam int MAP_COLS    = 16;
  localparam int MAP_ROWS    = 16;
  localparam int CELL_SIZE   = 64;
  localparam int MAX_STEPS   = 4096;
  localparam int DIR_ONE     = 1 << DIR_FRAC;
  localparam longint DIST_SAT = (longint'(1) << DIST_W) - 1;
  localparam int RANDOM_ITEMS = 1250;
  localparam int IDLE_PCT    = 31;
  localparam int TAIL_CYCLES = 64;

  // One result beat; member order matches the m_tdata layout.
  typedef struct packed {
    logic              limit;
    logic              blocked;
    logic [XY_W-1:0]   ly;
    logic [XY_W-1:0]   lx;
    logic [DIST_W-1:0] span;
  } ray_hit_t;

  // One input beat plus an optional hand-written result.
  typedef struct packed {
    item_kind_t              kind;
    logic [CELL_IDX_W-1:0]   col;
    logic [CELL_IDX_W-1:0]   row;
    logic                    wall;
    logic [XY_W-1:0]         sx;
    logic [XY_W-1:0]         sy;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic [STEP_W-1:0]       step_len;
    logic                    known;
    ray_hit_t                want;
  } map_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  bit        wall_cells [MAP_ROWS][MAP_COLS];
  ray_hit_t  pending_hits[$];
  map_item_t plan_rows[$];
  int        mismatches = 0;
  int        hits_seen = 0;
  bit        tx_calm = 1'b0;
  longint    cycles = 0;
  longint    cycle_budget = 5000;
  int unsigned rim_xy [4] = '{0, 63, 64, 1023};

  grid_ray_march_distance #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS),
    .CELL_SIZE(CELL_SIZE),
    .MAX_STEPS(MAX_STEPS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Marches the ray over the local copy of the map; steps returns the open points.
  function automatic ray_hit_t march_ray(input map_item_t it, output int steps);
    longint sx, sy, dx, dy, stp, off, nx, ny, lx, ly, travel;
    bit passable;
    ray_hit_t r;
    sx = longint'(it.sx);
    sy = longint'(it.sy);
    dx = longint'($signed(it.dx));
    dy = longint'($signed(it.dy));
    stp = longint'(it.step_len);
    lx = sx;
    ly = sy;
    steps = 0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      off = longint'(i) * stp;
      // Signed division truncates toward zero, as the hardware does.
      nx = (sx * DIR_ONE + off * dx) / DIR_ONE;
      ny = (sy * DIR_ONE + off * dy) / DIR_ONE;
      passable = nx >= 0 && ny >= 0 && nx / CELL_SIZE < MAP_COLS && ny / CELL_SIZE < MAP_ROWS;
      if (passable) passable = !wall_cells[ny / CELL_SIZE][nx / CELL_SIZE];
      if (!passable) break;
      lx = nx;
      ly = ny;
      steps = i + 1;
    end
    travel = longint'(steps) * stp;
    if (travel > DIST_SAT) travel = DIST_SAT;
    r.span    = travel[DIST_W-1:0];
    r.lx      = lx[XY_W-1:0];
    r.ly      = ly[XY_W-1:0];
    r.blocked = (steps == 0);
    r.limit   = (steps == MAX_STEPS);
    return r;
  endfunction

  function automatic ray_hit_t hit(input int span, input int lx, input int ly,
                                   input bit blocked, input bit limit);
    ray_hit_t r;
    r.span    = DIST_W'(span);
    r.lx      = XY_W'(lx);
    r.ly      = XY_W'(ly);
    r.blocked = blocked;
    r.limit   = limit;
    return r;
  endfunction

  // Directed rows; the fields a beat does not use get random fill.
  task automatic queue_cell_write(input int col, input int row, input bit wall);
    map_item_t it;
    it = '0;
    it.kind = KIND_WRITE;
    it.col = CELL_IDX_W'(col);
    it.row = CELL_IDX_W'(row);
    it.wall = wall;
    it.sx = XY_W'($urandom);
    it.sy = XY_W'($urandom);
    it.dx = DIR_W'($urandom);
    it.dy = DIR_W'($urandom);
    it.step_len = STEP_W'($urandom);
    plan_rows.push_back(it);
  endtask

  task automatic queue_ray(input int sx, input int sy, input int dx, input int dy,
                           input int step_len, input bit known, input ray_hit_t want);
    map_item_t it;
    it.kind = KIND_RAY;
    it.col = CELL_IDX_W'($urandom);
    it.row = CELL_IDX_W'($urandom);
    it.wall = 1'($urandom);
    it.sx = XY_W'(sx);
    it.sy = XY_W'(sy);
    it.dx = DIR_W'(dx);
    it.dy = DIR_W'(dy);
    it.step_len = STEP_W'(step_len);
    it.known = known;
    it.want = want;
    plan_rows.push_back(it);
  endtask

  // Presents one beat after a random gap (none while tx_calm is set), then updates the map or queues the expected hit.
  task automatic send_item(input map_item_t it);
    ray_hit_t want;
    int steps;
    while (!tx_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {{(IN_TDATA_W - OFF_STEP - STEP_W){1'b0}}, it.step_len, it.dy, it.dx,
                 it.sy, it.sx, it.wall, it.row, it.col};
    do @(posedge clk); while (!s_tready);
    if (it.kind == KIND_WRITE) begin
      wall_cells[it.row][it.col] = it.wall;
      cycle_budget += longint'(100);
    end else begin
      want = march_ray(it, steps);
      if (it.known) want = it.want;
      pending_hits.push_back(want);
      cycle_budget += longint'(200 + 16 * steps);
    end
  endtask

  // Holds the sender off until every queued hit has come back.
  task automatic drain_hits();
    s_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted beat, then pick the next ready value.
  always @(posedge clk) begin
    ray_hit_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_hits.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with none expected: %h", hits_seen, m_tdata);
          mismatches++;
        end else begin
          want = pending_hits.pop_front();
          if (got.span !== want.span || got.lx !== want.lx || got.ly !== want.ly ||
              got.blocked !== want.blocked || got.limit !== want.limit) begin
            if (mismatches < 10)
              $display({"result %0d: expected dist=%0d last=(%0d,%0d) blk=%0b lim=%0b,",
                        " got dist=%0d last=(%0d,%0d) blk=%0b lim=%0b"},
                       hits_seen, want.span, want.lx, want.ly, want.blocked, want.limit,
                       got.span, got.lx, got.ly, got.blocked, got.limit);
            mismatches++;
          end
        end
        hits_seen++;
      end
      m_tready <= (hits_seen >= 300 && hits_seen < 450) || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog; the budget grows with every accepted beat.
  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_budget) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    map_item_t it;

    // Directed table: rows with a hit written out are results plain from the geometry.
    queue_ray(0, 0, -DIR_ONE, 0, 1, 1, hit(1, 0, 0, 0, 0));
    queue_ray(1023, 1023, DIR_ONE, DIR_ONE, 63, 1, hit(63, 1023, 1023, 0, 0));
    queue_ray(512, 512, 0, 0, 63, 1, hit(258048, 512, 512, 0, 1));
    queue_ray(100, 200, DIR_ONE, 0, 0, 1, hit(0, 100, 200, 0, 1));
    queue_cell_write(0, 0, 1);
    queue_ray(5, 5, DIR_ONE, 0, 9, 1, hit(0, 5, 5, 1, 0));
    queue_ray(5, 5, 0, DIR_ONE, 0, 1, hit(0, 5, 5, 1, 0));
    queue_cell_write(15, 15, 1);
    queue_ray(1023, 1023, -DIR_ONE, -DIR_ONE, 63, 1, hit(0, 1023, 1023, 1, 0));
    queue_cell_write(0, 0, 0);
    queue_ray(0, 0, 0, -DIR_ONE, 1, 1, hit(1, 0, 0, 0, 0));
    queue_cell_write(8, 4, 1);
    queue_ray(10, 300, DIR_ONE, 0, 16, 0, '0);
    // A tiny negative direction truncates to zero for many steps.
    queue_ray(0, 10, -1, 0, 63, 0, '0);
    queue_ray(1000, 20, -DIR_ONE, DIR_ONE, 7, 0, '0);
    // Codes beyond plus or minus one.
    queue_ray(300, 700, 16'h7FFF, 16'h8000, 5, 0, '0);
    queue_cell_write(15, 0, 1);
    queue_ray(1000, 900, 0, -DIR_ONE, 1, 0, '0);
    queue_ray(1023, 1023, -1, -1, 63, 1, hit(0, 1023, 1023, 1, 0));
    queue_cell_write(15, 15, 0);
    queue_ray(1023, 512, DIR_ONE, 0, 1, 1, hit(1, 1023, 512, 0, 0));
    queue_cell_write(15, 0, 0);
    queue_ray(512, 512, 1, 1, 63, 0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < plan_rows.size(); k++) send_item(plan_rows[k]);
    drain_hits();

    // Random part: writes keep the map about a third walls, rays mostly unit directions.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      int pick;
      real ang;
      tx_calm = (n >= 300 && n < 500);
      it = '0;
      it.kind = ($urandom_range(0, 99) < 30) ? KIND_WRITE : KIND_RAY;
      it.col  = CELL_IDX_W'($urandom);
      it.row  = CELL_IDX_W'($urandom);
      it.wall = ($urandom_range(0, 99) < 30);
      it.sx   = XY_W'(($urandom_range(0, 4) == 0) ? rim_xy[$urandom_range(0, 3)] : $urandom);
      it.sy   = XY_W'(($urandom_range(0, 4) == 0) ? rim_xy[$urandom_range(0, 3)] : $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        ang = $urandom_range(0, 35999) * 6.283185307179586 / 36000.0;
        it.dx = DIR_W'($rtoi(DIR_ONE * $cos(ang)));
        it.dy = DIR_W'($rtoi(DIR_ONE * $sin(ang)));
      end else if (pick < 72) begin
        case ($urandom_range(0, 3))
          0: it.dx = DIR_W'(DIR_ONE);
          1: it.dx = DIR_W'(-DIR_ONE);
          2: it.dy = DIR_W'(DIR_ONE);
          default: it.dy = DIR_W'(-DIR_ONE);
        endcase
      end else if (pick < 90) begin
        it.dx = DIR_W'($urandom);
        it.dy = DIR_W'($urandom);
      end else if (pick < 98) begin
        it.dx = DIR_W'($urandom_range(0, 8192) - 4096);
        it.dy = DIR_W'($urandom_range(0, 8192) - 4096);
      end else begin
        // Near-zero direction: usually runs to the step limit.
        it.dx = DIR_W'($urandom_range(0, 6) - 3);
        it.dy = DIR_W'($urandom_range(0, 6) - 3);
      end
      it.step_len = STEP_W'(($urandom_range(0, 99) == 0) ? 0 : $urandom_range(1, 63));
      send_item(it);
      if (n == RANDOM_ITEMS / 2) drain_hits();
    end
    tx_calm = 1'b0;

    drain_hits();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
